@@ rtl/keyframe_vec4_interpolator_core_assert.svh @@
// Assertion macros shared by the interpolator core.
`ifndef KEYFRAME_VEC4_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_VEC4_INTERPOLATOR_CORE_ASSERT_SVH

// An implication checked at every rising clock edge while out of reset.
`define KVI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold at the next clock edge after the antecedent.
`define KVI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kvi_pkg.sv @@
package kvi_pkg;
    localparam int MAX_KEYS_DEF = 16;
    localparam int QW = 24;
    localparam int FRAC = 16;
    localparam int NUM_WORDS = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_KIND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_SLOT = 2'd2;

    localparam logic [3:0] WORD_TIME  = 4'd0;
    localparam logic [3:0] WORD_BLEND = 4'd1;
    localparam logic [3:0] WORD_VEC_LAST = 4'd9;

    localparam logic signed [QW-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [QW-1:0] Q_MIN = -24'sh800000;

    typedef logic signed [QW-1:0] q_t;

    function automatic q_t sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return Q_MAX;
        end else if (v < -64'sd8388608) begin
            return Q_MIN;
        end
        return q_t'(v);
    endfunction

    // Arithmetic shift right equals floor division by 2^16.
    function automatic logic signed [63:0] fsh16(input logic signed [63:0] v);
        return v >>> FRAC;
    endfunction
endpackage

@@ rtl/kvi_div.sv @@
module kvi_div (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  logic signed [40:0] num,
    input  logic signed [24:0] den,
    output logic done,
    output logic signed [40:0] quo
);
    import kvi_pkg::*;

    logic [40:0] rem_reg, rem_next;
    logic [40:0] q_reg, q_next;
    logic [24:0] d_reg;
    logic neg_reg;
    logic [5:0] cnt_reg;
    logic busy_reg;
    logic [41:0] trial;

    always_comb begin
        trial = {rem_reg, q_reg[40]} - {17'd0, d_reg};
        if (!trial[41]) begin
            rem_next = trial[40:0];
            q_next = {q_reg[39:0], 1'b1};
        end else begin
            rem_next = {rem_reg[39:0], q_reg[40]};
            q_next = {q_reg[39:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd41;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg <= num[40] ? 41'(-num) : num;
            d_reg <= den[24] ? 25'(-den) : den;
            neg_reg <= num[40] ^ den[24];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg <= q_next;
        end
    end

    assign quo = neg_reg ? 41'(-q_reg) : q_reg;
endmodule

@@ rtl/kvi_mem.sv @@
module kvi_mem #(
    parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF,
    localparam int AW = $clog2(MAX_KEYS)
) (
    input  logic aclk,
    input  logic wr_en,
    input  logic [AW-1:0] wr_key,
    input  logic [3:0] wr_word,
    input  logic signed [23:0] wr_data,
    input  logic [AW-1:0] rd_key,
    input  logic [3:0] rd_word,
    output logic signed [23:0] rd_data
);
    import kvi_pkg::*;

    localparam int DEPTH = MAX_KEYS * 16;
    logic [23:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[{wr_key, wr_word}] <= wr_data;
        end
        rd_data <= mem[{rd_key, rd_word}];
    end
endmodule

@@ rtl/keyframe_vec4_interpolator_core.sv @@
// Keyframe interpolator. Keyframe words live in one synchronous memory
// addressed by key and word, read one word per cycle. A write transaction
// leaves the block idle, so writes can follow back to back. An evaluation
// reads the end times, walks the cursor over the keyframes (no walk when
// the time clamps to an end), fetches the segment start, runs the 41-step
// serial divider (skipped when the span is zero), applies smoothstep when
// the blend word is set, and interpolates each of the eight components in
// turn. Segment, divider and smoothstep steps are skipped when the cursor
// lands on keyframe 0. A new transaction is accepted the cycle after the
// result is taken. Config writes are only accepted while the block is idle.
module keyframe_vec4_interpolator_core #(
    parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // mode, key_slot, key_word, word_value, now_time; zero filled to 64 bits
    input  logic [63:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // color_r, color_g, color_b, color_a, vec_x, vec_y, vec_z, vec_w,
    // segment, kind_out, slot_out; zero filled to 208 bits
    output logic [207:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import kvi_pkg::*;
    `include "keyframe_vec4_interpolator_core_assert.svh"

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = AW + 1;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_RD0   = 11'b00000000010,
        ST_RDN   = 11'b00000000100,
        ST_WALK  = 11'b00000001000,
        ST_RDT0  = 11'b00000010000,
        ST_DIV   = 11'b00000100000,
        ST_SM    = 11'b00001000000,
        ST_RDA   = 11'b00010000000,
        ST_RDB   = 11'b00100000000,
        ST_MUL   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg;
    logic [4:0] key_count_reg;
    logic light_kind_reg;
    logic [7:0] light_slot_reg;
    logic [AW-1:0] cursor_reg;
    logic [CW-1:0] n_reg;
    q_t now_reg, t0_reg, t1_reg, ta_reg, tk0_reg, a_reg;
    logic blend_reg;
    logic [2:0] comp_reg;
    logic [1:0] sm_reg, sub_reg;
    logic signed [47:0] s_reg;
    logic signed [63:0] prod_reg;
    q_t res_reg [8];
    logic m_valid_reg;

    logic mode;
    logic [3:0] key_slot, key_word;
    q_t word_value, now_time;
    assign mode = s_tdata[0];
    assign key_slot = s_tdata[4:1];
    assign key_word = s_tdata[8:5];
    assign word_value = s_tdata[32:9];
    assign now_time = s_tdata[56:33];

    logic s_acc;
    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_acc = s_tvalid && s_tready;
    assign cfg_ready = s_tready;

    logic wr_en;
    logic [AW-1:0] rd_key;
    logic [3:0] rd_word;
    q_t rd_data;
    assign wr_en = s_acc && !mode && ({28'd0, key_slot} < 32'(MAX_KEYS))
                   && (key_word <= WORD_VEC_LAST);

    kvi_mem #(.MAX_KEYS(MAX_KEYS)) u_mem (
        .aclk(aclk), .wr_en(wr_en), .wr_key(AW'(key_slot)), .wr_word(key_word),
        .wr_data(word_value), .rd_key(rd_key), .rd_word(rd_word), .rd_data(rd_data)
    );

    logic signed [24:0] span;
    assign span = {t1_reg[23], t1_reg} - {tk0_reg[23], tk0_reg};
    logic signed [24:0] now_diff;
    assign now_diff = {now_reg[23], now_reg} - {tk0_reg[23], tk0_reg};
    logic signed [40:0] div_num;
    assign div_num = {now_diff, 16'd0};

    logic div_start, div_done;
    logic signed [40:0] div_quo;
    kvi_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(span),
        .done(div_done), .quo(div_quo)
    );

    logic [CW-1:0] n_eff;
    assign n_eff = ({27'd0, key_count_reg} > 32'(MAX_KEYS)) ? CW'(MAX_KEYS)
                   : CW'(key_count_reg);
    logic [AW-1:0] last;
    assign last = AW'(n_reg - CW'(1));

    logic [AW-1:0] k0;
    assign k0 = cursor_reg - AW'(1);
    logic [3:0] comp_word;
    assign comp_word = 4'd2 + {1'b0, comp_reg};

    always_comb begin
        rd_key = '0;
        rd_word = WORD_TIME;
        unique case (state_reg)
            ST_RD0: rd_key = last;
            ST_RDN: rd_key = last;
            ST_WALK: rd_key = cursor_reg;
            ST_RDT0: begin
                rd_key = k0;
            end
            ST_DIV: begin
                rd_key = cursor_reg;
                rd_word = WORD_BLEND;
            end
            ST_RDA: begin
                rd_key = (cursor_reg == '0) ? cursor_reg : k0;
                rd_word = comp_word;
            end
            ST_RDB: begin
                rd_key = cursor_reg;
                rd_word = comp_word;
            end
            default: begin
                rd_key = '0;
                rd_word = WORD_TIME;
            end
        endcase
    end

    assign div_start = (state_reg == ST_RDT0) && (sub_reg == 2'd1) && (span != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            key_count_reg <= '0;
            light_kind_reg <= 1'b0;
            light_slot_reg <= '0;
            cursor_reg <= '0;
            m_valid_reg <= 1'b0;
            sub_reg <= '0;
            sm_reg <= '0;
            comp_reg <= '0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_KEY_COUNT: key_count_reg <= cfg_data[4:0];
                    CFG_LIGHT_KIND: light_kind_reg <= cfg_data[0];
                    CFG_LIGHT_SLOT: light_slot_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && mode && n_eff != '0) begin
                        now_reg <= now_time;
                        n_reg <= n_eff;
                        state_reg <= ST_RD0;
                    end
                end
                ST_RD0: begin
                    // rd_data holds time[0] here; time[n-1] follows in ST_RDN and the first ST_WALK step.
                    t0_reg <= rd_data;
                    state_reg <= ST_RDN;
                end
                ST_RDN: begin
                    state_reg <= ST_WALK;
                    sub_reg <= 2'd0;
                end
                ST_WALK: begin
                    if (sub_reg == 2'd0) begin
                        sub_reg <= 2'd1;
                        if (now_reg <= t0_reg) begin
                            cursor_reg <= '0;
                        end else if (now_reg >= rd_data) begin
                            cursor_reg <= last;
                        end else if ({1'b0, cursor_reg} > CW'(n_reg - CW'(1))) begin
                            cursor_reg <= last;
                        end
                        if (now_reg <= t0_reg || now_reg >= rd_data) begin
                            sub_reg <= 2'd3;
                        end
                    end else if (sub_reg == 2'd1) begin
                        sub_reg <= 2'd2;
                    end else if (sub_reg == 2'd2) begin
                        if (cursor_reg < last && rd_data < now_reg) begin
                            cursor_reg <= cursor_reg + AW'(1);
                            sub_reg <= 2'd1;
                        end else begin
                            sub_reg <= 2'd3;
                        end
                    end else begin
                        sub_reg <= 2'd0;
                        comp_reg <= '0;
                        state_reg <= (cursor_reg == '0) ? ST_RDA : ST_RDT0;
                    end
                end
                ST_RDT0: begin
                    if (sub_reg == 2'd0) begin
                        t1_reg <= rd_data;
                        sub_reg <= 2'd2;
                    end else if (sub_reg == 2'd2) begin
                        tk0_reg <= rd_data;
                        sub_reg <= 2'd3;
                    end else if (sub_reg == 2'd3) begin
                        sub_reg <= 2'd1;
                    end else begin
                        if (span == '0) begin
                            s_reg <= '0;
                            sm_reg <= 2'd3;
                        end else begin
                            sm_reg <= 2'd0;
                        end
                        sub_reg <= 2'd0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    blend_reg <= rd_data[0];
                    sub_reg <= 2'd1;
                    if (sub_reg == 2'd1 && (sm_reg == 2'd3 || div_done)) begin
                        if (sm_reg != 2'd3) begin
                            s_reg <= 48'(sat24(64'(div_quo)));
                        end
                        sm_reg <= 2'd0;
                        state_reg <= ST_SM;
                    end
                end
                ST_SM: begin
                    if (!blend_reg) begin
                        state_reg <= ST_RDA;
                    end else if (sm_reg == 2'd0) begin
                        prod_reg <= 64'(s_reg) * 64'(s_reg);
                        sm_reg <= 2'd1;
                    end else if (sm_reg == 2'd1) begin
                        ta_reg <= q_t'(s_reg);
                        s_reg <= 48'(fsh16(prod_reg));
                        sm_reg <= 2'd2;
                    end else if (sm_reg == 2'd2) begin
                        prod_reg <= 64'(s_reg) * (64'sd196608 - 64'(ta_reg) * 64'sd2);
                        sm_reg <= 2'd3;
                    end else begin
                        s_reg <= 48'(sat24(fsh16(prod_reg)));
                        blend_reg <= 1'b0;
                    end
                end
                ST_RDA: state_reg <= ST_RDB;
                ST_RDB: begin
                    a_reg <= rd_data;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (cursor_reg == '0) begin
                        res_reg[comp_reg] <= a_reg;
                    end else begin
                        res_reg[comp_reg] <= sat24(64'(a_reg) + fsh16(
                            (64'(rd_data) - 64'(a_reg)) * 64'(s_reg)));
                    end
                    comp_reg <= comp_reg + 3'd1;
                    state_reg <= (comp_reg == 3'd7) ? ST_OUT : ST_RDA;
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {3'd0, light_slot_reg, light_kind_reg, 4'(cursor_reg),
                      res_reg[7], res_reg[6], res_reg[5], res_reg[4],
                      res_reg[3], res_reg[2], res_reg[1], res_reg[0]};

    `KVI_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn,
        state_reg != ST_IDLE, !s_tready, "input accepted while busy")
    `KVI_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `KVI_ASSERT_IMPL(a_cursor_range, aclk, aresetn,
        state_reg == ST_OUT, {1'b0, cursor_reg} < n_reg, "cursor beyond key count")
endmodule
